// ===== src/dicc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the dithered indexed color converter.
// No dependencies; used by the core and by the inverse table RAM.
package dicc_pkg;

    localparam int PIX_W      = 8;    // channel, index and error width
    localparam int ADDR_W     = 15;   // table_addr field width
    localparam int ERR_WORD_W = 3 * PIX_W;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int START_W    = 3;    // width of the phase start configuration value

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL       = 2'd0,
        CMD_LOAD_INV    = 2'd1,
        CMD_LOAD_DITHER = 2'd2,
        CMD_FRAME       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_OPAQUE = 2'd0,
        MODE_SKIP   = 2'd1,
        MODE_BG     = 2'd2,
        MODE_XOR    = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_X_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_INDEX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR_PIXEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MASK = 3'd5;

    // one item as it travels down the pipeline
    typedef struct packed {
        cmd_t                  cmd;
        logic [PIX_W-1:0]      red;
        logic [PIX_W-1:0]      green;
        logic [PIX_W-1:0]      blue;
        logic                  opaque;
        logic [PIX_W-1:0]      dst_index;
        logic [ADDR_W-1:0]     table_addr;
        logic [PIX_W-1:0]      entry_value;
        logic [ERR_WORD_W-1:0] err_word;     // red lowest
    } item_t;

endpackage

// ===== src/dicc_inv_ram.sv =====
`timescale 1ns / 1ps
// Inverse color table: one write port, one registered read port.
// Depends on dicc_pkg for the entry width.
module dicc_inv_ram #(
    parameter int ADDR_W = 15
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [dicc_pkg::PIX_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [dicc_pkg::PIX_W-1:0] wr_data
);

    logic [dicc_pkg::PIX_W-1:0] mem [2**ADDR_W];
    logic [dicc_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/dithered_indexed_color_convert_core.sv =====
`timescale 1ns / 1ps
// Dithered RGB to palette index converter, top level.
// Depends on dicc_pkg and dicc_inv_ram.
//
// Takes one item per clock while the output is not stalled by m_tready, and
// returns one result item per input item, in order. One stage forms the
// modulo product for dither loads, one forms a partial remainder, one
// finishes the remainder and reads or writes the dither table, one reads or
// writes the inverse table, and the output register holds the result. The
// dither table and the inverse table each see one read and one write per
// cycle, and each is read and written in a single stage, so items touch them
// strictly in order and no forwarding is needed. Every stage has its own
// valid bit, so a bubble lets a new item in while a result waits on m_tready.
// Tables come up with undefined contents and need no clearing pass; reset
// only clears the pipeline, the phase counters and the configuration registers.
module dithered_indexed_color_convert_core #(
    parameter int CHANNEL_BITS = 5,
    parameter int DITHER_DIM   = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata, lowest bit up: red[7:0], green[15:8], blue[23:16], opaque[24],
    // dst_index[32:25], table_addr[47:33], entry_value[55:48],
    // err_red[63:56], err_green[71:64], err_blue[79:72]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dicc_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,   // row_end
    input  logic [dicc_pkg::CMD_W-1:0]          s_tuser,   // cmd
    // m_tdata, lowest bit up: out_index[7:0], write_enable[8], zeros
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dicc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [dicc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dicc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int PIX_W     = dicc_pkg::PIX_W;
    localparam int ADDR_W    = dicc_pkg::ADDR_W;
    localparam int PHASE_W   = $clog2(DITHER_DIM);
    localparam int DITH_SIZE = DITHER_DIM * DITHER_DIM;
    localparam int DITH_AW   = $clog2(DITH_SIZE);
    localparam int R0_W      = DITH_AW + 1;
    localparam int INV_AW    = 3 * CHANNEL_BITS;
    localparam int MOD_SHIFT = 16;
    localparam int MOD_RECIP = (1 << MOD_SHIFT) / DITH_SIZE;
    localparam int RECIP_W   = $clog2(MOD_RECIP + 1);
    localparam int PROD_W    = ADDR_W + RECIP_W;
    localparam int Q_W       = PROD_W - MOD_SHIFT;

    // ---------------------------------------------------------------- config
    logic [PHASE_W-1:0]    x_start_reg;
    logic [PHASE_W-1:0]    y_start_reg;
    dicc_pkg::mode_t       mode_reg;
    logic [PIX_W-1:0]      bg_index_reg;
    logic [PIX_W-1:0]      xor_pixel_reg;
    logic [PIX_W-1:0]      alpha_mask_reg;

    // start value modulo the dither size; at most eight subtract steps
    function automatic logic [PHASE_W-1:0] phase_mod(input logic [dicc_pkg::START_W-1:0] v);
        int acc;
        acc = int'(v);
        for (int i = 0; i < 8; i++) begin
            if (acc >= DITHER_DIM) begin
                acc = acc - DITHER_DIM;
            end
        end
        return PHASE_W'(acc);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_start_reg    <= '0;
            y_start_reg    <= '0;
            mode_reg       <= dicc_pkg::MODE_OPAQUE;
            bg_index_reg   <= '0;
            xor_pixel_reg  <= '0;
            alpha_mask_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                dicc_pkg::CFG_X_START:    x_start_reg <= phase_mod(cfg_wdata[2:0]);
                dicc_pkg::CFG_Y_START:    y_start_reg <= phase_mod(cfg_wdata[2:0]);
                dicc_pkg::CFG_MODE:       mode_reg <= dicc_pkg::mode_t'(cfg_wdata[1:0]);
                dicc_pkg::CFG_BG_INDEX:   bg_index_reg <= cfg_wdata;
                dicc_pkg::CFG_XOR_PIXEL:  xor_pixel_reg <= cfg_wdata;
                dicc_pkg::CFG_ALPHA_MASK: alpha_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------ pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic ready1, ready2, ready3, ready4, out_free;
    logic adv1, adv2, adv3, adv4, s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign ready4   = !v4_reg || out_free;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign adv4     = v4_reg && out_free;
    assign adv3     = v3_reg && ready4;
    assign adv2     = v2_reg && ready3;
    assign adv1     = v1_reg && ready2;
    assign s_tready = ready1;
    assign s_accept = s_tvalid && ready1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= s_accept || (v1_reg && !adv1);
            v2_reg      <= adv1 || (v2_reg && !adv2);
            v3_reg      <= adv2 || (v3_reg && !adv3);
            v4_reg      <= adv3 || (v4_reg && !adv4);
            m_valid_reg <= adv4 || (m_valid_reg && !m_tready);
        end
    end

    // ------------------------------------------------- input and dither phase
    dicc_pkg::item_t item_in;

    always_comb begin
        item_in.cmd         = dicc_pkg::cmd_t'(s_tuser);
        item_in.red         = s_tdata[7:0];
        item_in.green       = s_tdata[15:8];
        item_in.blue        = s_tdata[23:16];
        item_in.opaque      = s_tdata[24];
        item_in.dst_index   = s_tdata[32:25];
        item_in.table_addr  = s_tdata[47:33];
        item_in.entry_value = s_tdata[55:48];
        item_in.err_word    = s_tdata[79:56];
    end

    logic [PHASE_W-1:0] x_phase_reg, x_phase_next, x_inc;
    logic [PHASE_W-1:0] y_phase_reg, y_phase_next, y_inc;
    logic [DITH_AW-1:0] p_in;

    always_comb begin
        x_inc = (x_phase_reg == PHASE_W'(DITHER_DIM - 1)) ? '0 : x_phase_reg + PHASE_W'(1);
        y_inc = (y_phase_reg == PHASE_W'(DITHER_DIM - 1)) ? '0 : y_phase_reg + PHASE_W'(1);
        p_in  = DITH_AW'(int'(y_phase_reg) * DITHER_DIM + int'(x_phase_reg));
        x_phase_next = x_phase_reg;
        y_phase_next = y_phase_reg;
        if (s_accept) begin
            case (item_in.cmd)
                dicc_pkg::CMD_FRAME: begin
                    x_phase_next = x_start_reg;
                    y_phase_next = y_start_reg;
                end
                dicc_pkg::CMD_PIXEL: begin
                    if (s_tlast) begin
                        x_phase_next = x_start_reg;
                        y_phase_next = y_inc;
                    end else begin
                        x_phase_next = x_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_phase_reg <= '0;
            y_phase_reg <= '0;
        end else begin
            x_phase_reg <= x_phase_next;
            y_phase_reg <= y_phase_next;
        end
    end

    // ------------------------------------------- stage 1: reciprocal product
    dicc_pkg::item_t    s1_item_reg;
    logic [DITH_AW-1:0] s1_p_reg;
    logic [PROD_W-1:0]  s1_prod_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= item_in;
            s1_p_reg    <= p_in;
            s1_prod_reg <= PROD_W'(item_in.table_addr) * PROD_W'(MOD_RECIP);
        end
    end

    // ------------------------------------------------ stage 2: partial remainder
    // quotient estimate is exact or one short, so the remainder is below 2x size
    dicc_pkg::item_t    s2_item_reg;
    logic [DITH_AW-1:0] s2_p_reg;
    logic [R0_W-1:0]    s2_r0_reg;
    logic [Q_W-1:0]     quot_est;
    logic [15:0]        quot_mul;
    logic [15:0]        rem_full;

    always_comb begin
        quot_est = s1_prod_reg[PROD_W-1 -: Q_W];
        quot_mul = 16'(int'(quot_est) * DITH_SIZE);
        rem_full = 16'(s1_item_reg.table_addr) - quot_mul;
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s2_item_reg <= s1_item_reg;
            s2_p_reg    <= s1_p_reg;
            s2_r0_reg   <= R0_W'(rem_full);
        end
    end

    // ------------------------------------------------ stage 3: dither table
    logic [dicc_pkg::ERR_WORD_W-1:0] dith_mem [DITH_SIZE];
    logic [dicc_pkg::ERR_WORD_W-1:0] dith_rd_reg;
    logic [DITH_AW-1:0]              dith_wr_addr;
    dicc_pkg::item_t                 s3_item_reg;

    assign dith_wr_addr = (s2_r0_reg >= R0_W'(DITH_SIZE)) ?
                          DITH_AW'(s2_r0_reg - R0_W'(DITH_SIZE)) : DITH_AW'(s2_r0_reg);

    always_ff @(posedge aclk) begin
        if (adv2) begin
            if (s2_item_reg.cmd == dicc_pkg::CMD_LOAD_DITHER) begin
                dith_mem[dith_wr_addr] <= s2_item_reg.err_word;
            end
            dith_rd_reg <= dith_mem[s2_p_reg];
            s3_item_reg <= s2_item_reg;
        end
    end

    // ------------------------------------------------ stage 4: inverse table
    // add signed error, clamp to 0..255, keep the top bits
    function automatic logic [CHANNEL_BITS-1:0] reduce(input logic [PIX_W-1:0] chan,
                                                       input logic [PIX_W-1:0] err);
        logic [PIX_W+1:0] sum;
        logic [PIX_W-1:0] clamped;
        sum = {2'b00, chan} + {{2{err[PIX_W-1]}}, err};
        if (sum[PIX_W+1]) begin
            clamped = '0;
        end else if (sum[PIX_W]) begin
            clamped = '1;
        end else begin
            clamped = sum[PIX_W-1:0];
        end
        return clamped[PIX_W-1 -: CHANNEL_BITS];
    endfunction

    logic [INV_AW-1:0] inv_rd_addr;
    logic [PIX_W-1:0]  inv_rd_data;
    logic              inv_wr_en;
    dicc_pkg::item_t   s4_item_reg;

    always_comb begin
        if (mode_reg == dicc_pkg::MODE_XOR) begin
            inv_rd_addr = {s3_item_reg.red[PIX_W-1 -: CHANNEL_BITS],
                           s3_item_reg.green[PIX_W-1 -: CHANNEL_BITS],
                           s3_item_reg.blue[PIX_W-1 -: CHANNEL_BITS]};
        end else begin
            inv_rd_addr = {reduce(s3_item_reg.red,   dith_rd_reg[7:0]),
                           reduce(s3_item_reg.green, dith_rd_reg[15:8]),
                           reduce(s3_item_reg.blue,  dith_rd_reg[23:16])};
        end
    end

    assign inv_wr_en = adv3 && (s3_item_reg.cmd == dicc_pkg::CMD_LOAD_INV);

    dicc_inv_ram #(
        .ADDR_W (INV_AW)
    ) u_inv_ram (
        .clk     (aclk),
        .rd_en   (adv3),
        .rd_addr (inv_rd_addr),
        .rd_data (inv_rd_data),
        .wr_en   (inv_wr_en),
        .wr_addr (INV_AW'(s3_item_reg.table_addr)),
        .wr_data (s3_item_reg.entry_value)
    );

    always_ff @(posedge aclk) begin
        if (adv3) begin
            s4_item_reg <= s3_item_reg;
        end
    end

    // ------------------------------------------------ result and output register
    logic [PIX_W-1:0] res_index;
    logic             res_we;
    logic [PIX_W-1:0] m_index_reg;
    logic             m_we_reg;

    always_comb begin
        res_index = s4_item_reg.dst_index;
        res_we    = 1'b0;
        if (s4_item_reg.cmd == dicc_pkg::CMD_PIXEL) begin
            case (mode_reg)
                dicc_pkg::MODE_XOR: begin
                    if (s4_item_reg.opaque) begin
                        res_index = s4_item_reg.dst_index ^
                                    ((inv_rd_data ^ xor_pixel_reg) & ~alpha_mask_reg);
                        res_we    = 1'b1;
                    end
                end
                dicc_pkg::MODE_BG: begin
                    res_index = s4_item_reg.opaque ? inv_rd_data : bg_index_reg;
                    res_we    = 1'b1;
                end
                dicc_pkg::MODE_SKIP: begin
                    if (s4_item_reg.opaque) begin
                        res_index = inv_rd_data;
                        res_we    = 1'b1;
                    end
                end
                default: begin
                    res_index = inv_rd_data;
                    res_we    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            m_index_reg <= res_index;
            m_we_reg    <= res_we;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(dicc_pkg::OUT_DATA_W - PIX_W - 1){1'b0}}, m_we_reg, m_index_reg};

    // ------------------------------------------------ assertions
    a_frame_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && item_in.cmd == dicc_pkg::CMD_FRAME) |=>
            (x_phase_reg == $past(x_start_reg) && y_phase_reg == $past(y_start_reg)))
        else $error("frame start did not reload dither phases");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(x_phase_reg) < DITHER_DIM && int'(y_phase_reg) < DITHER_DIM))
        else $error("dither phase out of range");

    a_load_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv4 && s4_item_reg.cmd != dicc_pkg::CMD_PIXEL) |=>
            (!m_we_reg && m_index_reg == $past(s4_item_reg.dst_index)))
        else $error("non-pixel item produced a destination write");

    a_xor_transparent: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv4 && s4_item_reg.cmd == dicc_pkg::CMD_PIXEL && mode_reg == dicc_pkg::MODE_XOR
         && !s4_item_reg.opaque) |=> !m_we_reg)
        else $error("transparent pixel written in xor mode");

endmodule
